@@ hdl/ssfm_pkg.sv @@
package ssfm_pkg;

    localparam int SLOTS  = 1024;
    localparam int LINKS  = 64;
    localparam int LANES  = 32;
    localparam int WORDS  = SLOTS / LANES;
    localparam int WORD_W = $clog2(WORDS);
    localparam int LANE_W = $clog2(LANES);
    localparam int ROW_W  = $clog2(LINKS);
    localparam int ADDR_W = ROW_W + WORD_W;
    localparam int DEPTH  = LINKS * WORDS;
    localparam int DATA_W = 2 * LANES;
    localparam int IDX_W  = WORD_W + LANE_W;
    localparam int EXT_W  = 13;

    localparam logic [1:0] CODE_FREE  = 2'd0;
    localparam logic [1:0] CODE_USED  = 2'd1;
    localparam logic [1:0] CODE_GUARD = 2'd2;

    typedef struct packed {
        logic [EXT_W-1:0] first;
        logic [EXT_W-1:0] last;
        logic [EXT_W-1:0] guard;
    } range_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage

@@ hdl/spectrum_slot_first_fit_marker.sv @@
// A request reads and rewrites the slot map words of link_first, then those of
// link_second if it differs; no new request is taken until the result is loaded.
// The slot map memory has one read port and one write port; it handles one word of
// 32 slots per cycle. Reset: rst_n is asynchronous, active low. After reset all
// LINKS*WORDS (2048) slot map words are cleared one per cycle; in_stall stays high.
module spectrum_slot_first_fit_marker
    import ssfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [9:0] slot_count,
    input  logic [9:0] start_slot,
    input  logic [5:0] link_first,
    input  logic [5:0] link_second,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] first_free_slot,
    output logic [9:0] highest_used_slot,
    output logic       no_free_found,
    output logic       range_clipped
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [WORD_W:0]   cnt_reg;
    logic [ROW_W-1:0]  row_a_reg, row_b_reg;
    range_t            rng_reg;
    logic              p_vld_reg, p_is_a_reg;
    logic [ADDR_W-1:0] p_addr_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  first_reg;
    logic              out_valid_reg;
    logic [9:0]        ffs_reg, hus_reg;
    logic              nff_reg, rc_reg;

    logic              accept, issue, last_issue, load_out;
    logic [ROW_W-1:0]  rd_row;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [DATA_W-1:0] rdata, wdata, mod_word;
    logic              we, has_free;
    logic [LANE_W-1:0] free_lane;
    logic [EXT_W-1:0]  last_in;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign issue      = (state_reg == ST_RUN);
    assign rd_row     = cnt_reg[WORD_W] ? row_b_reg : row_a_reg;
    assign raddr      = {rd_row, cnt_reg[WORD_W-1:0]};
    assign last_issue = issue && (&cnt_reg[WORD_W-1:0])
                        && (cnt_reg[WORD_W] || row_a_reg == row_b_reg);
    assign load_out   = (state_reg == ST_DRAIN) && !p_vld_reg
                        && (!out_valid_reg || !out_stall);
    assign last_in    = EXT_W'(start_slot) + EXT_W'(slot_count);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            p_vld_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_vld_reg <= issue;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (p_vld_reg && p_is_a_reg && has_free && !found_reg)
            begin
                found_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg <= raddr;
        p_is_a_reg <= !cnt_reg[WORD_W];
        if (accept)
        begin
            row_a_reg     <= ROW_W'(link_first % LINKS);
            row_b_reg     <= ROW_W'(link_second % LINKS);
            rng_reg.first <= EXT_W'(start_slot);
            rng_reg.last  <= last_in;
            rng_reg.guard <= last_in + 1'b1;
        end
        if (p_vld_reg && p_is_a_reg && has_free && !found_reg)
        begin
            first_reg <= {p_addr_reg[WORD_W-1:0], free_lane};
        end
        if (load_out)
        begin
            ffs_reg <= found_reg ? 10'(first_reg) : 10'd0;
            nff_reg <= !found_reg;
            hus_reg <= (rng_reg.last < EXT_W'(SLOTS)) ? 10'(rng_reg.last)
                                                      : 10'(SLOTS - 1);
            rc_reg  <= (rng_reg.guard >= EXT_W'(SLOTS));
        end
    end

    ssfm_word_mod u_mod (
        .word_in   (rdata),
        .word_idx  (p_addr_reg[WORD_W-1:0]),
        .rng       (rng_reg),
        .word_out  (mod_word),
        .has_free  (has_free),
        .free_lane (free_lane)
    );

    assign we    = (state_reg == ST_CLEAR) || p_vld_reg;
    assign waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : p_addr_reg;
    assign wdata = (state_reg == ST_CLEAR) ? '0 : mod_word;

    ssfm_ram #(
        .AW (ADDR_W),
        .DW (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_valid         = out_valid_reg;
    assign first_free_slot   = ffs_reg;
    assign highest_used_slot = hus_reg;
    assign no_free_found     = nff_reg;
    assign range_clipped     = rc_reg;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !p_vld_reg)
        else $error("slot map written while idle");
    a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DRAIN)
        else $error("result raised outside drain");
    a_stall_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("request taken during clear");
`endif

endmodule

@@ hdl/ssfm_ram.sv @@
module ssfm_ram #(
    parameter int AW = 11,
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ssfm_word_mod.sv @@
module ssfm_word_mod
    import ssfm_pkg::*;
(
    input  logic [DATA_W-1:0] word_in,
    input  logic [WORD_W-1:0] word_idx,
    input  range_t            rng,
    output logic [DATA_W-1:0] word_out,
    output logic              has_free,
    output logic [LANE_W-1:0] free_lane
);

    always_comb
    begin
        logic [EXT_W-1:0] idx;
        logic [1:0]       code;
        word_out  = word_in;
        has_free  = 1'b0;
        free_lane = '0;
        for (int i = 0; i < LANES; i++)
        begin
            idx  = EXT_W'({word_idx, LANE_W'(i)});
            code = word_in[2*i +: 2];
            if (idx >= rng.first && idx <= rng.last)
            begin
                code = CODE_USED;
            end
            else if (idx == rng.guard)
            begin
                code = CODE_GUARD;
            end
            word_out[2*i +: 2] = code;
        end
        // Highest lane first so the lowest free lane wins.
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (word_out[2*i +: 2] == CODE_FREE)
            begin
                has_free  = 1'b1;
                free_lane = LANE_W'(i);
            end
        end
    end

endmodule
